// File: src/mrma_pkg.sv
package mrma_pkg;

  localparam int MAP_RADIUS = 511;
  localparam int MAP_SIDE   = 2 * MAP_RADIUS + 1;
  localparam int MAP_CELLS  = MAP_SIDE * MAP_SIDE;
  localparam int CELL_AW    = $clog2(MAP_CELLS);
  localparam int CRD_W      = $clog2(MAP_SIDE);
  localparam int POS_W      = 14;

  localparam int NCH     = 3;
  localparam int PIX_W   = 8;
  localparam int MEAN_W  = 16;
  localparam int CNT_W   = 8;
  localparam int NUM_W   = MEAN_W + CNT_W;
  localparam int WORD_W  = NCH * MEAN_W + CNT_W;
  localparam int STAT_W  = 3;

  localparam int RECIP_SH = NUM_W;
  localparam int RECIP_W  = RECIP_SH + 1;

  localparam logic [MEAN_W-1:0] MEAN_MAX   = 16'hFF00;
  localparam logic [CNT_W-1:0]  MAX_SAMP_RST = 8'd250;
  localparam logic [WORD_W-1:0] CELL_INIT  = {8'd0, 16'h0000, 16'hFF00, 16'h0000};

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = FIFO_AW + 1;

  typedef enum logic [STAT_W-1:0] {
    ST_UPDATED   = 3'd0,
    ST_MASKED    = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_SATURATED = 3'd3,
    ST_READ      = 3'd4
  } status_t;

  typedef struct packed {
    logic [CELL_AW-1:0] addr;
    logic               upd;
    status_t            status;
    logic               in_map;
    logic [CNT_W-1:0]   cnt;
  } ctl_t;

  typedef struct packed {
    status_t            status;
    logic [PIX_W-1:0]   mean_blue;
    logic [PIX_W-1:0]   mean_green;
    logic [PIX_W-1:0]   mean_red;
    logic [CNT_W-1:0]   sample_count;
  } out_word_t;

  typedef logic [RECIP_W-1:0] recip_tab_t [256];

  // floor(2^RECIP_SH / d) by long division
  function automatic logic [RECIP_W-1:0] recip_of(input int unsigned d);
    logic [CNT_W:0]     rem;
    logic [RECIP_W-1:0] q;
    rem = '0;
    q   = '0;
    for (int i = RECIP_SH; i >= 0; i--) begin
      rem = {rem[CNT_W-1:0], (i == RECIP_SH)};
      if (rem >= (CNT_W+1)'(d)) begin
        rem  = rem - (CNT_W+1)'(d);
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic recip_tab_t build_recip();
    recip_tab_t t;
    t[0] = '0;
    for (int i = 1; i < 256; i++) begin
      t[i] = recip_of(i);
    end
    return t;
  endfunction

  localparam recip_tab_t RECIP_TAB = build_recip();

  function automatic logic [PIX_W-1:0] round_mean(input logic [MEAN_W-1:0] m);
    logic [MEAN_W:0] s;
    s = {1'b0, m} + (MEAN_W+1)'(128);
    return (s[MEAN_W:8] > 9'd255) ? 8'd255 : s[15:8];
  endfunction

endpackage

// File: src/mosaic_running_mean_accumulator.sv
// channel   | handshake            | word
// ----------+----------------------+------------------------------------------
// input     | in_valid / in_ready  | command, pixel_x/y, offset_x/y, masked_in,
//           |                      | blue, green, red
// output    | out_valid/out_ready  | status, mean_blue/green/red, sample_count
// config    | cfg_we               | cfg_wdata -> max_samples
//
// One word per cycle unless a hazard, full output credit or the RAM clear holds
// in_ready low. Stages from input accept to output FIFO write: issue, RAM read and
// numerator, reciprocal multiply, remainder check, write back. A word that hits a
// cell still being updated further down waits in the issue stage until that write lands.
// After reset the cell RAM is cleared one cell a cycle, all 1046529 cells, with
// in_ready low. An 8-deep output FIFO with occupancy credit absorbs out_ready stalls.
module mosaic_running_mean_accumulator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mrma_pkg::CNT_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        command,
  input  logic [9:0]                  pixel_x,
  input  logic [9:0]                  pixel_y,
  input  logic signed [11:0]          offset_x,
  input  logic signed [11:0]          offset_y,
  input  logic                        masked_in,
  input  logic [mrma_pkg::PIX_W-1:0]  blue,
  input  logic [mrma_pkg::PIX_W-1:0]  green,
  input  logic [mrma_pkg::PIX_W-1:0]  red,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mrma_pkg::STAT_W-1:0] status,
  output logic [mrma_pkg::PIX_W-1:0]  mean_blue,
  output logic [mrma_pkg::PIX_W-1:0]  mean_green,
  output logic [mrma_pkg::PIX_W-1:0]  mean_red,
  output logic [mrma_pkg::CNT_W-1:0]  sample_count
);

  import mrma_pkg::*;

  // config and clear
  logic [CNT_W-1:0]   max_samples;
  logic               clr_busy;
  logic [CELL_AW-1:0] clr_addr;

  // position
  logic signed [POS_W-1:0] px, py;
  logic                    in_inside;
  logic                    in_acc, out_acc;

  // issue stage
  logic               a_valid, a_cmd, a_mask, a_inside;
  logic [CRD_W-1:0]   a_px, a_py;
  logic [PIX_W-1:0]   a_pix [NCH];
  logic [CELL_AW-1:0] a_addr;
  logic               a_wp, hazard, a_go;

  // read stage
  logic               b_valid, b_cmd, b_mask, b_inside, b_wp;
  logic [CELL_AW-1:0] b_addr;
  logic [PIX_W-1:0]   b_pix [NCH];
  logic [WORD_W-1:0]  ram_rdata;
  logic [CNT_W-1:0]   b_n;
  logic [CNT_W-1:0]   b_d;
  logic [CNT_W-1:0]   b_half;
  logic [NUM_W-1:0]   b_num [NCH];
  ctl_t               b_ctl;

  // reciprocal multiply stage
  logic                     c_valid;
  ctl_t                     c_ctl;
  logic [NCH*MEAN_W-1:0]    c_old;
  logic [NUM_W-1:0]         c_num [NCH];
  logic [CNT_W-1:0]         c_d;
  logic [RECIP_W-1:0]       c_r;
  logic [NUM_W+RECIP_W-1:0] c_prod [NCH];

  // remainder stage
  logic                  d_valid;
  ctl_t                  d_ctl;
  logic [NCH*MEAN_W-1:0] d_old;
  logic [NUM_W-1:0]      d_num [NCH];
  logic [NUM_W-1:0]      d_q0 [NCH];
  logic [CNT_W-1:0]      d_d;
  logic [NUM_W-1:0]      d_rem [NCH];
  logic                  d_bump [NCH];

  // write-back stage
  logic                  e_valid;
  ctl_t                  e_ctl;
  logic [NCH*MEAN_W-1:0] e_old;
  logic [NUM_W-1:0]      e_q0 [NCH];
  logic                  e_bump [NCH];
  logic [NUM_W-1:0]      e_q [NCH];
  logic [NCH*MEAN_W-1:0] e_new;
  logic [NCH*MEAN_W-1:0] e_rep;
  logic [CNT_W-1:0]      e_cnt;
  out_word_t             e_word;

  // RAM port
  logic               ram_we;
  logic [CELL_AW-1:0] ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;

  // output FIFO
  out_word_t          fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [OCC_W-1:0]   fifo_cnt;
  logic [OCC_W-1:0]   occ;
  out_word_t          head;

  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      max_samples <= MAX_SAMP_RST;
    end else if (cfg_we) begin
      max_samples <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + CELL_AW'(1);
      if (clr_addr == CELL_AW'(MAP_CELLS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  assign px = $signed(POS_W'(MAP_RADIUS)) + $signed({{(POS_W-10){1'b0}}, pixel_x})
            + $signed({{(POS_W-12){offset_x[11]}}, offset_x});
  assign py = $signed(POS_W'(MAP_RADIUS)) + $signed({{(POS_W-10){1'b0}}, pixel_y})
            + $signed({{(POS_W-12){offset_y[11]}}, offset_y});
  assign in_inside = !px[POS_W-1] && (px < $signed(POS_W'(MAP_SIDE)))
                  && !py[POS_W-1] && (py < $signed(POS_W'(MAP_SIDE)));

  assign a_addr = CELL_AW'(CELL_AW'(a_py) * CELL_AW'(MAP_SIDE)) + CELL_AW'(a_px);
  assign a_wp   = (a_cmd == CMD_ACCUM) && a_mask && a_inside;

  assign hazard = a_inside && (
      (b_valid && b_wp && (b_addr == a_addr)) ||
      (c_valid && c_ctl.upd && (c_ctl.addr == a_addr)) ||
      (d_valid && d_ctl.upd && (d_ctl.addr == a_addr)) ||
      (e_valid && e_ctl.upd && (e_ctl.addr == a_addr)));
  assign a_go = a_valid && !hazard;

  assign in_ready = !clr_busy && (occ < OCC_W'(FIFO_DEPTH)) && (!a_valid || a_go);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_acc) begin
      a_valid <= 1'b1;
    end else if (a_go) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_cmd    <= command;
      a_mask   <= masked_in;
      a_inside <= in_inside;
      a_px     <= px[CRD_W-1:0];
      a_py     <= py[CRD_W-1:0];
      a_pix[0] <= blue;
      a_pix[1] <= green;
      a_pix[2] <= red;
    end
  end

  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      b_valid <= a_go;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_cmd    <= a_cmd;
    b_mask   <= a_mask;
    b_inside <= a_inside;
    b_wp     <= a_wp;
    b_addr   <= a_addr;
    b_pix    <= a_pix;
  end

  assign b_n    = ram_rdata[NCH*MEAN_W +: CNT_W];
  assign b_d    = b_n + CNT_W'(1);
  assign b_half = CNT_W'(({1'b0, b_n} + (CNT_W+1)'(1)) >> 1);

  always_comb begin
    b_ctl.addr   = b_addr;
    b_ctl.in_map = b_inside;
    b_ctl.cnt    = b_n;
    if (b_cmd == CMD_READ) begin
      b_ctl.status = b_inside ? ST_READ : ST_OUTSIDE;
    end else if (!b_mask) begin
      b_ctl.status = ST_MASKED;
    end else if (!b_inside) begin
      b_ctl.status = ST_OUTSIDE;
    end else if (b_n >= max_samples) begin
      b_ctl.status = ST_SATURATED;
    end else begin
      b_ctl.status = ST_UPDATED;
    end
    b_ctl.upd = (b_ctl.status == ST_UPDATED);
  end

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      b_num[k] = NUM_W'(ram_rdata[k*MEAN_W +: MEAN_W]) * NUM_W'(b_n)
               + NUM_W'({b_pix[k], 8'd0}) + NUM_W'(b_half);
    end
  end

  always_ff @(posedge clk) begin
    c_ctl <= b_ctl;
    c_old <= ram_rdata[NCH*MEAN_W-1:0];
    c_num <= b_num;
    c_d   <= b_d;
    c_r   <= RECIP_TAB[b_d];
  end

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      c_prod[k] = (NUM_W+RECIP_W)'(c_num[k]) * (NUM_W+RECIP_W)'(c_r);
    end
  end

  always_ff @(posedge clk) begin
    d_ctl <= c_ctl;
    d_old <= c_old;
    d_num <= c_num;
    d_d   <= c_d;
    for (int k = 0; k < NCH; k++) begin
      d_q0[k] <= c_prod[k][RECIP_SH +: NUM_W];
    end
  end

  // estimate is exact or one low
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      d_rem[k]  = d_num[k] - NUM_W'(d_q0[k] * NUM_W'(d_d));
      d_bump[k] = d_rem[k] >= NUM_W'(d_d);
    end
  end

  always_ff @(posedge clk) begin
    e_ctl  <= d_ctl;
    e_old  <= d_old;
    e_q0   <= d_q0;
    e_bump <= d_bump;
  end

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      e_q[k] = e_q0[k] + NUM_W'(e_bump[k]);
      e_new[k*MEAN_W +: MEAN_W] = (e_q[k] > NUM_W'(MEAN_MAX)) ? MEAN_MAX
                                                              : e_q[k][MEAN_W-1:0];
    end
  end

  assign e_rep = e_ctl.upd ? e_new : e_old;
  assign e_cnt = e_ctl.upd ? e_ctl.cnt + CNT_W'(1) : e_ctl.cnt;

  always_comb begin
    e_word.status = e_ctl.status;
    if (e_ctl.in_map) begin
      e_word.mean_blue    = round_mean(e_rep[0*MEAN_W +: MEAN_W]);
      e_word.mean_green   = round_mean(e_rep[1*MEAN_W +: MEAN_W]);
      e_word.mean_red     = round_mean(e_rep[2*MEAN_W +: MEAN_W]);
      e_word.sample_count = e_cnt;
    end else begin
      e_word.mean_blue    = '0;
      e_word.mean_green   = '0;
      e_word.mean_red     = '0;
      e_word.sample_count = '0;
    end
  end

  // ---------------------------------------------------------------------------
  assign ram_we    = clr_busy || (e_valid && e_ctl.upd);
  assign ram_waddr = clr_busy ? clr_addr : e_ctl.addr;
  assign ram_wdata = clr_busy ? CELL_INIT : {e_cnt, e_new};

  mrma_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (a_addr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (e_valid) begin
      fifo_mem[wr_ptr] <= e_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      occ      <= '0;
    end else begin
      if (e_valid) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_cnt <= fifo_cnt + OCC_W'(e_valid) - OCC_W'(out_acc);
      occ      <= occ + OCC_W'(in_acc) - OCC_W'(out_acc);
    end
  end

  assign head         = fifo_mem[rd_ptr];
  assign out_valid    = (fifo_cnt != '0);
  assign status       = head.status;
  assign mean_blue    = head.mean_blue;
  assign mean_green   = head.mean_green;
  assign mean_red     = head.mean_red;
  assign sample_count = head.sample_count;

  // ---------------------------------------------------------------------------
  a_no_clr_collision: assert property (@(posedge clk) disable iff (rst)
    (e_valid && e_ctl.upd) |-> !clr_busy)
    else $error("pipeline write during RAM clear");

  a_occ_tracks: assert property (@(posedge clk) disable iff (rst)
    occ == fifo_cnt + OCC_W'(a_valid) + OCC_W'(b_valid) + OCC_W'(c_valid)
         + OCC_W'(d_valid) + OCC_W'(e_valid))
    else $error("occupancy credit out of step with pipeline");

  a_fifo_room: assert property (@(posedge clk) disable iff (rst)
    e_valid |-> (fifo_cnt < OCC_W'(FIFO_DEPTH)) || out_acc)
    else $error("output FIFO overflow");

  a_update_counts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_UPDATED)) |-> (sample_count != '0))
    else $error("updated cell reports zero samples");

endmodule

// File: src/mrma_ram.sv
module mrma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/mosaic_running_mean_accumulator_tb.sv
`timescale 1ns / 1ps

module mosaic_running_mean_accumulator_tb;
  import mrma_pkg::*;

  typedef struct packed {
    logic               command;
    logic [9:0]         pixel_x;
    logic [9:0]         pixel_y;
    logic signed [11:0] offset_x;
    logic signed [11:0] offset_y;
    logic               masked_in;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
  } pixel_word_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    pixel_word_t word;
    logic        typed;
    out_word_t   want;
    logic [7:0]  cfg_value;
  } stim_row_t;

  localparam int HOT_CELLS = 6;
  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 85;
  localparam logic [2:0][15:0] GREEN_MEANS = {16'h0000, 16'hFF00, 16'h0000};

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic command;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;
  logic signed [11:0] offset_x;
  logic signed [11:0] offset_y;
  logic masked_in;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] red;
  logic out_valid;
  logic out_ready;
  logic [STAT_W-1:0] status;
  logic [PIX_W-1:0] mean_blue;
  logic [PIX_W-1:0] mean_green;
  logic [PIX_W-1:0] mean_red;
  logic [CNT_W-1:0] sample_count;

  logic [2:0][15:0] cell_mean_store [int];
  logic [7:0] cell_count_store [int];
  logic [7:0] max_samples_model;

  out_word_t pending_results [$];
  stim_row_t dir_rows [$];
  int hot_cx [HOT_CELLS];
  int hot_cy [HOT_CELLS];
  int fail_count = 0;
  int results_seen = 0;
  int words_sent = 0;
  int cfg_writes = 0;

  mosaic_running_mean_accumulator DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .offset_x(offset_x),
    .offset_y(offset_y),
    .masked_in(masked_in),
    .blue(blue),
    .green(green),
    .red(red),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .mean_blue(mean_blue),
    .mean_green(mean_green),
    .mean_red(mean_red),
    .sample_count(sample_count)
  );

  always #1 clk = ~clk;

  initial begin
    #10_000_000;
    $display("timeout: %0d words still expected", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [7:0] mean_to_pixel(logic [15:0] m);
    int unsigned r;
    r = (32'(m) + 128) >> 8;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic out_word_t predict_cell_step(pixel_word_t w);
    out_word_t res;
    int px, py, cell_idx;
    int unsigned n, num, q;
    logic [2:0][15:0] m;
    logic [7:0] pix [3];
    logic in_map;
    status_t st;
    px = MAP_RADIUS + int'(w.pixel_x) + int'($signed(w.offset_x));
    py = MAP_RADIUS + int'(w.pixel_y) + int'($signed(w.offset_y));
    in_map = (px >= 0) && (px < MAP_SIDE) && (py >= 0) && (py < MAP_SIDE);
    cell_idx = py * MAP_SIDE + px;
    m = cell_mean_store.exists(cell_idx) ? cell_mean_store[cell_idx] : GREEN_MEANS;
    n = cell_count_store.exists(cell_idx) ? int'(cell_count_store[cell_idx]) : 0;
    pix[0] = w.blue;
    pix[1] = w.green;
    pix[2] = w.red;
    if (w.command == CMD_READ) begin
      st = in_map ? ST_READ : ST_OUTSIDE;
    end else if (!w.masked_in) begin
      st = ST_MASKED;
    end else if (!in_map) begin
      st = ST_OUTSIDE;
    end else if (n >= int'(max_samples_model)) begin
      st = ST_SATURATED;
    end else begin
      st = ST_UPDATED;
      for (int k = 0; k < 3; k++) begin
        num = 32'(m[k]) * n + (32'(pix[k]) << 8) + ((n + 1) >> 1);
        q = num / (n + 1);
        if (q > 32'(MEAN_MAX)) q = 32'(MEAN_MAX);
        m[k] = q[15:0];
      end
      n = n + 1;
      cell_mean_store[cell_idx] = m;
      cell_count_store[cell_idx] = n[7:0];
    end
    res.status = st;
    if (in_map) begin
      res.mean_blue = mean_to_pixel(m[0]);
      res.mean_green = mean_to_pixel(m[1]);
      res.mean_red = mean_to_pixel(m[2]);
      res.sample_count = n[7:0];
    end else begin
      res.mean_blue = '0;
      res.mean_green = '0;
      res.mean_red = '0;
      res.sample_count = '0;
    end
    return res;
  endfunction

  function automatic pixel_word_t pw(logic cmd, int x, int y, int ox, int oy, logic msk,
                                     int b, int g, int r);
    pixel_word_t w;
    w.command = cmd;
    w.pixel_x = 10'(x);
    w.pixel_y = 10'(y);
    w.offset_x = 12'(ox);
    w.offset_y = 12'(oy);
    w.masked_in = msk;
    w.blue = 8'(b);
    w.green = 8'(g);
    w.red = 8'(r);
    return w;
  endfunction

  function automatic logic [7:0] random_channel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 8'd0;
    if (r < 12) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pixel_word_t random_word();
    pixel_word_t w;
    int cx, cy, x, y, h;
    w.command = 1'($urandom_range(0, 1));
    w.pixel_x = 10'($urandom_range(0, 1023));
    w.pixel_y = 10'($urandom_range(0, 1023));
    w.offset_x = 12'($urandom_range(0, 4095));
    w.offset_y = 12'($urandom_range(0, 4095));
    w.masked_in = 1'($urandom_range(0, 1));
    w.blue = random_channel();
    w.green = random_channel();
    w.red = random_channel();
    if ($urandom_range(0, 99) >= 12) begin
      if ($urandom_range(0, 99) < 80) begin
        h = $urandom_range(0, HOT_CELLS - 1);
        cx = hot_cx[h];
        cy = hot_cy[h];
      end else begin
        cx = $urandom_range(0, MAP_SIDE - 1);
        cy = $urandom_range(0, MAP_SIDE - 1);
      end
      x = int'(w.pixel_x);
      y = int'(w.pixel_y);
      w.offset_x = 12'(cx - MAP_RADIUS - x);
      w.offset_y = 12'(cy - MAP_RADIUS - y);
      w.command = ($urandom_range(0, 99) < 20) ? CMD_READ : CMD_ACCUM;
      w.masked_in = ($urandom_range(0, 99) < 88);
    end
    return w;
  endfunction

  function automatic int pick_gap(logic burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_word(pixel_word_t w);
    stim_row_t row;
    row.kind = ROW_WORD;
    row.word = w;
    row.typed = 1'b0;
    row.want = '0;
    row.cfg_value = '0;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic add_typed(pixel_word_t w, status_t st, int b, int g, int r, int cnt);
    stim_row_t row;
    row.kind = ROW_WORD;
    row.word = w;
    row.typed = 1'b1;
    row.want.status = st;
    row.want.mean_blue = 8'(b);
    row.want.mean_green = 8'(g);
    row.want.mean_red = 8'(r);
    row.want.sample_count = 8'(cnt);
    row.cfg_value = '0;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic add_cfg(int v);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.word = '0;
    row.typed = 1'b0;
    row.want = '0;
    row.cfg_value = 8'(v);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic send_word(pixel_word_t w, logic typed, out_word_t want, int gap);
    out_word_t predicted;
    command <= w.command;
    pixel_x <= w.pixel_x;
    pixel_y <= w.pixel_y;
    offset_x <= w.offset_x;
    offset_y <= w.offset_y;
    masked_in <= w.masked_in;
    blue <= w.blue;
    green <= w.green;
    red <= w.red;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = predict_cell_step(w);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    words_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_max_samples(logic [7:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_samples_model = v;
    cfg_writes++;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with none expected: status %0d", status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", int'(want.status), int'(status));
        check_field("mean_blue", int'(want.mean_blue), int'(mean_blue));
        check_field("mean_green", int'(want.mean_green), int'(mean_green));
        check_field("mean_red", int'(want.mean_red), int'(mean_red));
        check_field("sample_count", int'(want.sample_count), int'(sample_count));
      end
    end
  end

  initial begin : result_sink
    int hold_left, taken, cyc, r;
    hold_left = 0;
    taken = 0;
    cyc = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (out_valid && out_ready) begin
        taken++;
        // long back-pressure so the pipeline and output buffer fill
        if (hold_left == 0 && (taken % 150) == 40) hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if ((cyc % 400) < 100) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready <= 1'b1;
        end else if (r < 97) begin
          out_ready <= 1'b0;
        end else begin
          hold_left = $urandom_range(8, 30);
          out_ready <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0] phase_max [PHASES];
    int r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    command = CMD_ACCUM;
    pixel_x = '0;
    pixel_y = '0;
    offset_x = '0;
    offset_y = '0;
    masked_in = 1'b0;
    blue = '0;
    green = '0;
    red = '0;
    cell_mean_store.delete();
    cell_count_store.delete();
    max_samples_model = MAX_SAMP_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    add_typed(pw(CMD_READ, 0, 0, -511, -511, 0, 0, 0, 0), ST_READ, 0, 255, 0, 0);
    add_typed(pw(CMD_READ, 1023, 1023, -512, -512, 1, 255, 255, 255), ST_READ, 0, 255, 0, 0);
    add_typed(pw(CMD_ACCUM, 0, 0, -511, -511, 1, 255, 0, 255), ST_UPDATED, 255, 0, 255, 1);
    add_word(pw(CMD_ACCUM, 1023, 1023, -1534, -1534, 1, 0, 255, 0));
    add_word(pw(CMD_READ, 511, 511, -1022, -1022, 0, 0, 0, 0));
    add_typed(pw(CMD_ACCUM, 1023, 1023, -512, -512, 1, 0, 0, 0), ST_UPDATED, 0, 0, 0, 1);
    add_typed(pw(CMD_ACCUM, 1023, 0, 2047, 0, 1, 7, 7, 7), ST_OUTSIDE, 0, 0, 0, 0);
    add_typed(pw(CMD_ACCUM, 0, 0, -2048, -2048, 1, 7, 7, 7), ST_OUTSIDE, 0, 0, 0, 0);
    add_typed(pw(CMD_READ, 1023, 5, -511, 0, 1, 0, 0, 0), ST_OUTSIDE, 0, 0, 0, 0);
    add_typed(pw(CMD_READ, 5, 0, 0, -512, 0, 0, 0, 0), ST_OUTSIDE, 0, 0, 0, 0);
    add_word(pw(CMD_ACCUM, 0, 1023, -511, -1534, 0, 9, 9, 9));
    add_typed(pw(CMD_ACCUM, 1023, 1023, 2047, 2047, 0, 1, 1, 1), ST_MASKED, 0, 0, 0, 0);
    add_typed(pw(CMD_ACCUM, 0, 1023, -511, -512, 0, 3, 3, 3), ST_MASKED, 0, 255, 0, 0);
    add_cfg(0);
    add_word(pw(CMD_ACCUM, 0, 0, -511, -511, 1, 1, 2, 3));
    add_typed(pw(CMD_ACCUM, 5, 5, -511, -511, 1, 4, 5, 6), ST_SATURATED, 0, 255, 0, 0);
    add_cfg(1);
    add_typed(pw(CMD_ACCUM, 5, 5, -511, -511, 1, 12, 34, 56), ST_UPDATED, 12, 34, 56, 1);
    add_word(pw(CMD_ACCUM, 5, 5, -511, -511, 1, 200, 200, 200));
    add_cfg(255);
    add_typed(pw(CMD_ACCUM, 300, 300, 0, 0, 1, 255, 255, 255), ST_UPDATED, 255, 255, 255, 1);
    add_word(pw(CMD_ACCUM, 300, 300, 0, 0, 1, 0, 0, 0));
    add_word(pw(CMD_ACCUM, 300, 300, 0, 0, 1, 128, 128, 128));
    add_word(pw(CMD_ACCUM, 300, 300, 0, 0, 1, 77, 1, 254));
    add_cfg(250);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_max_samples(dir_rows[i].cfg_value);
      end else begin
        send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want, pick_gap(1'b0));
      end
    end

    phase_max[0] = 8'd4;
    phase_max[1] = 8'd255;
    phase_max[2] = 8'd0;
    phase_max[3] = 8'd1;
    phase_max[4] = 8'($urandom_range(2, 20));
    phase_max[5] = MAX_SAMP_RST;
    for (int p = 0; p < PHASES; p++) begin
      write_max_samples(phase_max[p]);
      for (int h = 0; h < HOT_CELLS; h++) begin
        r = $urandom_range(0, 99);
        hot_cx[h] = (r < 15) ? 0 : (r < 30) ? MAP_SIDE - 1 : $urandom_range(0, MAP_SIDE - 1);
        r = $urandom_range(0, 99);
        hot_cy[h] = (r < 15) ? 0 : (r < 30) ? MAP_SIDE - 1 : $urandom_range(0, MAP_SIDE - 1);
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        send_word(random_word(), 1'b0, '0, pick_gap((i % 60) < 20));
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d pixel words and checked %0d result words", words_sent, results_seen);
    $display("max_samples written %0d times (0, 1, 4, 250, 255 and a random cap)",
             cfg_writes);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
